>>> rtl/core/urbe_pkg.sv
// Package for the serial port ring buffer engine.
// Holds mode codes, FSM state type and shared widths; no dependencies.
package urbe_pkg;

  localparam int unsigned BURST_MAX = 16;
  localparam int unsigned BURST_W   = 5;

  typedef enum logic [2:0] {
    MODE_RX_BYTE  = 3'd0,
    MODE_WRITE    = 3'd1,
    MODE_TX_EMPTY = 3'd2,
    MODE_LINE     = 3'd3,
    MODE_READ     = 3'd4,
    MODE_FLUSH    = 3'd5,
    MODE_QUERY    = 3'd6,
    MODE_UNUSED   = 3'd7
  } mode_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_EXEC  = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_SEND  = 5'b01000,
    ST_STAT  = 5'b10000
  } state_t;

  localparam logic [0:0] REG_TX_BURST = 1'b0;

endpackage

>>> rtl/core/urbe_ring_ram.sv
// Byte ring memory: one write port, one registered read port.
// Depends on nothing.
module urbe_ring_ram #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];

  // Write and read with registered output
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/core/uart_ring_buffer_engine.sv
// A result beat follows the EXEC state and then STAT when no byte is sent; when
// bytes are sent, each takes a FETCH state (ring read) and a SEND state (output
// beat, held while the receiver stalls) through the single transmit ring read port.
// Flow: one item at a time, taken once the last beat has left. Synchronous
// reset clears pointers, busy flag and counters, sets tx_burst to 16 and leaves
// ring contents as they are.
// Depends on urbe_pkg and urbe_ring_ram.
module uart_ring_buffer_engine #(
  parameter int unsigned TX_DEPTH = 4096,
  parameter int unsigned RX_DEPTH = 4096
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [15:0]  s_tdata,  // data_byte[7:0], line_status[10:8], zero pad [15:11]
  input  logic [2:0]   s_tuser,  // mode[2:0]
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [127:0] m_tdata,  // tx_valid[0], tx_data[8:1], rx_valid[9],
                                 // rx_data[17:10], accepted[18], rx_level[30:19],
                                 // transmitting[31], overrun_total[63:32],
                                 // parity_total[95:64], framing_total[127:96]
  output logic         m_tlast,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [2:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready
);

  localparam int unsigned TAW = $clog2(TX_DEPTH);
  localparam int unsigned RAW = $clog2(RX_DEPTH);

  urbe_pkg::state_t state;
  logic [urbe_pkg::BURST_W-1:0] tx_burst;
  logic [TAW-1:0] tx_wp, tx_rp;
  logic [RAW-1:0] rx_wp, rx_rp;
  logic           tx_busy;
  logic [31:0]    ovr_cnt, par_cnt, frm_cnt;
  logic [2:0]     in_mode;
  logic [7:0]     in_data;
  logic           in_last;
  logic [2:0]     in_ls;
  logic [4:0]     sent, limit;
  logic           acc, rxv;
  logic [7:0]     rxd;
  logic           read_rx;
  logic [7:0]     tx_q, rx_q;
  logic           tx_v;
  logic [7:0]     tx_d;
  logic           wr_room, prime_go;

  // Ring pointer increments with wrap
  function automatic logic [TAW-1:0] tnext(input logic [TAW-1:0] p);
    return (32'(p) + 32'd1 >= TX_DEPTH) ? '0 : p + TAW'(1);
  endfunction
  function automatic logic [RAW-1:0] rnext(input logic [RAW-1:0] p);
    return (32'(p) + 32'd1 >= RX_DEPTH) ? '0 : p + RAW'(1);
  endfunction

  logic tx_we, rx_we;
  urbe_ring_ram #(.DEPTH(TX_DEPTH), .AW(TAW)) u_tx_ram (
    .clk(clk), .we(tx_we), .waddr(tx_wp), .wdata(in_data), .raddr(tx_rp), .rdata(tx_q)
  );
  urbe_ring_ram #(.DEPTH(RX_DEPTH), .AW(RAW)) u_rx_ram (
    .clk(clk), .we(rx_we), .waddr(rx_wp), .wdata(in_data), .raddr(rx_rp), .rdata(rx_q)
  );

  assign wr_room = (tnext(tx_wp) != tx_rp);
  assign prime_go = ((in_mode == urbe_pkg::MODE_WRITE) && in_last && !tx_busy)
                    || ((in_mode == urbe_pkg::MODE_TX_EMPTY) && (tx_wp != tx_rp));

  assign tx_we = (state == urbe_pkg::ST_EXEC) && (in_mode == urbe_pkg::MODE_WRITE)
                 && wr_room;
  assign rx_we = (state == urbe_pkg::ST_EXEC) && (in_mode == urbe_pkg::MODE_RX_BYTE);

  // Configuration port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == urbe_pkg::REG_TX_BURST) ? 32'(tx_burst) : 32'd0;

  // Clamp burst limit to 1..16
  always_comb begin
    if (tx_burst == '0) limit = 5'd1;
    else if (tx_burst > 5'(urbe_pkg::BURST_MAX)) limit = 5'(urbe_pkg::BURST_MAX);
    else limit = tx_burst;
  end

  logic [RAW-1:0] level_raw;
  logic [11:0]    level;
  always_comb begin
    level_raw = rx_wp - rx_rp;
    if (rx_wp < rx_rp) level_raw = rx_wp + RAW'(RX_DEPTH) - rx_rp;
    level = 12'(level_raw);
  end

  // Take a new item only once the previous result beat has left
  assign s_tready = (state == urbe_pkg::ST_IDLE) && (!m_tvalid || m_tready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= urbe_pkg::ST_IDLE;
      tx_burst <= 5'd16;
      tx_wp <= '0; tx_rp <= '0; rx_wp <= '0; rx_rp <= '0;
      tx_busy <= 1'b0;
      ovr_cnt <= '0; par_cnt <= '0; frm_cnt <= '0;
      m_tvalid <= 1'b0;
      read_rx <= 1'b0;
    end else begin
      if (psel && penable && pwrite && pready && paddr[2] == urbe_pkg::REG_TX_BURST
          && paddr[1:0] == 2'b00) begin
        tx_burst <= pwdata[urbe_pkg::BURST_W-1:0];
      end
      read_rx <= (state == urbe_pkg::ST_EXEC) && (in_mode == urbe_pkg::MODE_READ)
                 && (rx_rp != rx_wp);
      unique case (state)
        urbe_pkg::ST_IDLE: begin
          if (s_tvalid && s_tready) begin
            in_mode <= s_tuser;
            in_data <= s_tdata[7:0];
            in_last <= s_tlast;
            in_ls   <= s_tdata[10:8];
            state   <= urbe_pkg::ST_EXEC;
          end
        end
        urbe_pkg::ST_EXEC: begin
          acc <= (in_mode == urbe_pkg::MODE_WRITE) && wr_room;
          rxv <= (in_mode == urbe_pkg::MODE_READ) && (rx_rp != rx_wp);
          sent <= '0;
          state <= prime_go ? urbe_pkg::ST_FETCH : urbe_pkg::ST_STAT;
          unique case (urbe_pkg::mode_t'(in_mode))
            urbe_pkg::MODE_RX_BYTE: begin
              rx_wp <= rnext(rx_wp);
              if (rnext(rx_wp) == rx_rp) rx_rp <= rnext(rx_rp);
            end
            urbe_pkg::MODE_WRITE: begin
              if (wr_room) tx_wp <= tnext(tx_wp);
              if (in_last && !tx_busy) tx_busy <= 1'b1;
            end
            urbe_pkg::MODE_TX_EMPTY: begin
              if (tx_wp == tx_rp) tx_busy <= 1'b0;
            end
            urbe_pkg::MODE_LINE: begin
              if (in_ls[0]) ovr_cnt <= ovr_cnt + 32'd1;
              if (in_ls[1]) par_cnt <= par_cnt + 32'd1;
              if (in_ls[2]) frm_cnt <= frm_cnt + 32'd1;
            end
            urbe_pkg::MODE_READ: begin
              if (rx_rp != rx_wp) rx_rp <= rnext(rx_rp);
            end
            urbe_pkg::MODE_FLUSH: rx_wp <= rx_rp;
            default: ;
          endcase
        end
        urbe_pkg::ST_FETCH: begin
          // Ring read data for tx_rp lands next cycle
          if (sent == limit || tx_rp == tx_wp) begin
            if (sent == '0) state <= urbe_pkg::ST_STAT;
            else state <= urbe_pkg::ST_IDLE;
          end else begin
            state <= urbe_pkg::ST_SEND;
          end
        end
        urbe_pkg::ST_SEND: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            tx_v <= 1'b1;
            tx_d <= tx_q;
            tx_rp <= tnext(tx_rp);
            sent <= sent + 5'd1;
            m_tlast <= (sent + 5'd1 == limit) || (tnext(tx_rp) == tx_wp);
            state <= urbe_pkg::ST_FETCH;
          end
        end
        urbe_pkg::ST_STAT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            tx_v <= 1'b0;
            tx_d <= '0;
            m_tlast <= 1'b1;
            state <= urbe_pkg::ST_IDLE;
          end
        end
        default: state <= urbe_pkg::ST_IDLE;
      endcase
      if (m_tvalid && m_tready && !((state == urbe_pkg::ST_SEND)
          || (state == urbe_pkg::ST_STAT))) begin
        m_tvalid <= 1'b0;
      end
      // Latch the read byte in the cycle after the ring read
      if (read_rx) rxd <= rx_q;
      else if (state == urbe_pkg::ST_EXEC) rxd <= '0;
    end
  end

  // Status fields; all but tx_data are the same on every beat of one item
  assign m_tdata[0]      = tx_v;
  assign m_tdata[8:1]    = tx_d;
  assign m_tdata[9]      = rxv;
  assign m_tdata[17:10]  = rxd;
  assign m_tdata[18]     = acc;
  assign m_tdata[30:19]  = level;
  assign m_tdata[31]     = tx_busy;
  assign m_tdata[63:32]  = ovr_cnt;
  assign m_tdata[95:64]  = par_cnt;
  assign m_tdata[127:96] = frm_cnt;

endmodule

>>> sim/tb_top.sv
// Testbench for uart_ring_buffer_engine: random and directed stream items,
// predicted results checked beat by beat. Depends on urbe_pkg and the RTL.
module tb_top;

  localparam int DEPTH = 4096;
  localparam int LIMIT = 2000000;

  logic clk = 0;
  logic rst = 1;
  logic s_tvalid = 0;
  logic s_tready;
  logic [15:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic s_tlast = 0;
  logic m_tvalid;
  logic m_tready = 0;
  logic [127:0] m_tdata;
  logic m_tlast;
  logic psel = 0, penable = 0, pwrite = 0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  typedef struct packed {
    logic [31:0] framing;
    logic [31:0] parity;
    logic [31:0] overrun;
    logic        busy;
    logic [11:0] level;
    logic        acc;
    logic [7:0]  rdata;
    logic        rvalid;
    logic [7:0]  tdata;
    logic        tvalid;
  } beat_t;

  typedef struct {
    beat_t b;
    logic  lst;
  } exp_t;

  uart_ring_buffer_engine dut (.*);

  always #1 clk = ~clk;

  // shadow state of the engine
  logic [7:0]  tx_mem [DEPTH];
  logic [7:0]  rx_mem [DEPTH];
  int unsigned tx_wp, tx_rp, rx_wp, rx_rp;
  logic        tx_busy_s;
  logic [31:0] ovr_cnt, par_cnt, frm_cnt;
  int unsigned burst_sh;

  logic [15:0] item_q[$];
  exp_t        beats_q[$];
  int          errors = 0;
  int          cycles = 0;
  int          send_idle = 0, recv_stall = 0;
  int          hold_off = 0;
  logic        in_fire = 0;

  function automatic int unsigned nxt(int unsigned p);
    return (p + 1 >= DEPTH) ? 0 : p + 1;
  endfunction

  // compute expected beats for one accepted item
  task automatic predict_engine(logic [15:0] it);
    urbe_pkg::mode_t md;
    logic [7:0] d;
    logic wl;
    logic [2:0] ls;
    logic [7:0] sent[$];
    beat_t b;
    int unsigned lim, lvl;
    md = urbe_pkg::mode_t'(it[2:0]);
    d = it[10:3];
    wl = it[11];
    ls = it[14:12];
    b = '0;
    lim = burst_sh < 1 ? 1 : (burst_sh > 16 ? 16 : burst_sh);
    case (md)
      urbe_pkg::MODE_RX_BYTE: begin
        rx_mem[rx_wp] = d;
        rx_wp = nxt(rx_wp);
        if (rx_wp == rx_rp) rx_rp = nxt(rx_rp);
      end
      urbe_pkg::MODE_WRITE: begin
        if (nxt(tx_wp) != tx_rp) begin
          tx_mem[tx_wp] = d;
          tx_wp = nxt(tx_wp);
          b.acc = 1;
        end
        if (wl && !tx_busy_s) begin
          while (sent.size() < lim && tx_rp != tx_wp) begin
            sent.push_back(tx_mem[tx_rp]);
            tx_rp = nxt(tx_rp);
          end
          tx_busy_s = 1;
        end
      end
      urbe_pkg::MODE_TX_EMPTY: begin
        if (tx_wp == tx_rp) tx_busy_s = 0;
        else
          while (sent.size() < lim && tx_rp != tx_wp) begin
            sent.push_back(tx_mem[tx_rp]);
            tx_rp = nxt(tx_rp);
          end
      end
      urbe_pkg::MODE_LINE: begin
        if (ls[0]) ovr_cnt++;
        if (ls[1]) par_cnt++;
        if (ls[2]) frm_cnt++;
      end
      urbe_pkg::MODE_READ: begin
        if (rx_rp != rx_wp) begin
          b.rdata = rx_mem[rx_rp];
          b.rvalid = 1;
          rx_rp = nxt(rx_rp);
        end
      end
      urbe_pkg::MODE_FLUSH: rx_wp = rx_rp;
      default: ;
    endcase
    lvl = (rx_wp >= rx_rp) ? rx_wp - rx_rp : rx_wp + DEPTH - rx_rp;
    b.level = lvl[11:0];
    b.busy = tx_busy_s;
    b.overrun = ovr_cnt;
    b.parity = par_cnt;
    b.framing = frm_cnt;
    if (sent.size() == 0) begin
      beats_q.push_back('{b, 1'b1});
    end else begin
      foreach (sent[k]) begin
        b.tvalid = 1;
        b.tdata = sent[k];
        beats_q.push_back('{b, k == sent.size() - 1});
      end
    end
  endtask

  function automatic logic [15:0] pack_item(urbe_pkg::mode_t m, logic [7:0] d, logic wl,
                                            logic [2:0] ls);
    return {1'b0, ls, wl, d, m};
  endfunction

  // record accepted items at the rising edge
  always @(posedge clk) begin
    in_fire <= !rst && s_tvalid && s_tready;
    if (!rst && s_tvalid && s_tready) begin
      predict_engine({1'b0, s_tdata[10:8], s_tlast, s_tdata[7:0], s_tuser});
    end
  end

  // drive items at the falling edge
  always @(negedge clk) begin : drv
    logic [15:0] it;
    if (!rst && (!s_tvalid || in_fire)) begin
      if (item_q.size() > 0 && ($urandom_range(99) >= send_idle)) begin
        it = item_q.pop_front();
        s_tvalid <= 1;
        s_tuser <= it[2:0];
        s_tdata <= {5'b0, it[14:12], it[10:3]};
        s_tlast <= it[11];
      end else begin
        s_tvalid <= 0;
        s_tuser <= 3'($urandom);
        s_tdata <= {5'b0, 3'($urandom), 8'($urandom)};
        s_tlast <= 1'($urandom);
      end
    end
  end

  // receiver ready, with a counted hold-off
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        m_tready <= 0;
      end else begin
        m_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // check result beats at the rising edge
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && m_tvalid && m_tready) begin
      if (beats_q.size() == 0) begin
        $error("unexpected result beat %h", m_tdata);
        errors = errors + 1;
      end else begin
        exp_t e;
        beat_t a;
        e = beats_q.pop_front();
        a = beat_t'(m_tdata);
        if (a.tvalid !== e.b.tvalid) begin
          $error("tx_valid exp %0d got %0d", e.b.tvalid, a.tvalid); errors = errors + 1;
        end
        if (a.tdata !== e.b.tdata) begin
          $error("tx_data exp %0h got %0h", e.b.tdata, a.tdata); errors = errors + 1;
        end
        if (a.rvalid !== e.b.rvalid) begin
          $error("rx_valid exp %0d got %0d", e.b.rvalid, a.rvalid); errors = errors + 1;
        end
        if (a.rdata !== e.b.rdata) begin
          $error("rx_data exp %0h got %0h", e.b.rdata, a.rdata); errors = errors + 1;
        end
        if (a.acc !== e.b.acc) begin
          $error("accepted exp %0d got %0d", e.b.acc, a.acc); errors = errors + 1;
        end
        if (a.level !== e.b.level) begin
          $error("rx_level exp %0d got %0d", e.b.level, a.level); errors = errors + 1;
        end
        if (a.busy !== e.b.busy) begin
          $error("transmitting exp %0d got %0d", e.b.busy, a.busy); errors = errors + 1;
        end
        if (a.overrun !== e.b.overrun) begin
          $error("overrun_total exp %0d got %0d", e.b.overrun, a.overrun);
          errors = errors + 1;
        end
        if (a.parity !== e.b.parity) begin
          $error("parity_total exp %0d got %0d", e.b.parity, a.parity);
          errors = errors + 1;
        end
        if (a.framing !== e.b.framing) begin
          $error("framing_total exp %0d got %0d", e.b.framing, a.framing);
          errors = errors + 1;
        end
        if (m_tlast !== e.lst) begin
          $error("last exp %0d got %0d", e.lst, m_tlast); errors = errors + 1;
        end
      end
    end
  end

  // abort on a hung run
  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // wait until the engine is idle and every beat has come back
  task automatic drain();
    while (item_q.size() > 0 || s_tvalid || beats_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_burst(logic [31:0] v);
    @(negedge clk);
    psel <= 1; pwrite <= 1; penable <= 0;
    paddr <= {urbe_pkg::REG_TX_BURST, 2'b00}; pwdata <= v;
    @(negedge clk);
    penable <= 1;
    @(negedge clk);
    psel <= 0; penable <= 0; pwrite <= 0;
    burst_sh = v[4:0];
  endtask

  // one random item or write run, mostly well formed write runs and events
  task automatic push_random();
    int unsigned r;
    int unsigned n;
    r = $urandom_range(99);
    if (r < 30) begin
      n = $urandom_range(1, 6);
      for (int i = 0; i < n; i++)
        item_q.push_back(pack_item(urbe_pkg::MODE_WRITE, 8'($urandom), i == n - 1,
                                   3'($urandom)));
    end else if (r < 45) begin
      item_q.push_back(pack_item(urbe_pkg::MODE_TX_EMPTY, 8'($urandom), 1'($urandom),
                                 3'($urandom)));
    end else if (r < 65) begin
      item_q.push_back(pack_item(urbe_pkg::MODE_RX_BYTE, 8'($urandom), 1'($urandom),
                                 3'($urandom)));
    end else if (r < 80) begin
      item_q.push_back(pack_item(urbe_pkg::MODE_READ, 8'($urandom), 1'($urandom),
                                 3'($urandom)));
    end else if (r < 90) begin
      item_q.push_back(pack_item(urbe_pkg::MODE_LINE, 8'($urandom), 1'($urandom),
                                 3'($urandom)));
    end else begin
      item_q.push_back({1'b0, 3'($urandom), 1'($urandom), 8'($urandom),
                        3'($urandom_range(5, 7))});
    end
  endtask

  initial begin
    logic [31:0] bursts[6];
    tx_wp = 0; tx_rp = 0; rx_wp = 0; rx_rp = 0; tx_busy_s = 0;
    ovr_cnt = 0; par_cnt = 0; frm_cnt = 0; burst_sh = 16;
    bursts = '{16, 1, 0, 31, 5, 17};
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // directed: empty read, empty prime, field extremes, every mode
    item_q.push_back(pack_item(urbe_pkg::MODE_READ, 8'hff, 1, 3'd7));
    item_q.push_back(pack_item(urbe_pkg::MODE_TX_EMPTY, 8'h00, 0, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_WRITE, 8'h00, 1, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_TX_EMPTY, 8'h00, 0, 3'd0));
    for (int i = 0; i < 20; i++)
      item_q.push_back(pack_item(urbe_pkg::MODE_WRITE, 8'(i * 13 + 5), i == 19, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_TX_EMPTY, 8'hff, 1, 3'd7));
    item_q.push_back(pack_item(urbe_pkg::MODE_TX_EMPTY, 8'h00, 0, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_TX_EMPTY, 8'h00, 0, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_RX_BYTE, 8'hff, 1, 3'd7));
    item_q.push_back(pack_item(urbe_pkg::MODE_RX_BYTE, 8'h00, 0, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_LINE, 8'hff, 1, 3'd7));
    item_q.push_back(pack_item(urbe_pkg::MODE_LINE, 8'h00, 0, 3'd5));
    item_q.push_back(pack_item(urbe_pkg::MODE_READ, 8'h00, 0, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_QUERY, 8'h55, 1, 3'd2));
    item_q.push_back(pack_item(urbe_pkg::MODE_FLUSH, 8'haa, 0, 3'd0));
    item_q.push_back(pack_item(urbe_pkg::MODE_UNUSED, 8'hff, 1, 3'd7));
    drain();

    // random phases over several burst settings and idle mixes
    for (int ph = 0; ph < 6; ph++) begin
      write_burst(bursts[ph]);
      case (ph % 4)
        0: begin send_idle = 0; recv_stall = 0; end
        1: begin send_idle = 67; recv_stall = 0; end
        2: begin send_idle = 0; recv_stall = 67; end
        default: begin send_idle = 18; recv_stall = 18; end
      endcase
      for (int i = 0; i < 22; i++) push_random();
      if (ph == 2) begin
        // long receiver hold-off while items keep coming
        while (item_q.size() > 12) @(posedge clk);
        hold_off = 300;
      end
      drain();
    end

    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
